/* hdl/asa_pkg.sv */
// shared types, constants and helpers of the aligned span allocator
package asa_pkg;

   localparam int MAX_SPANS   = 32;
   localparam int MAX_ALLOCS  = 64;
   localparam int SPAN_IDX_W  = $clog2(MAX_SPANS);
   localparam int SPAN_CNT_W  = $clog2(MAX_SPANS + 1);
   localparam int ALLOC_IDX_W = (MAX_ALLOCS > 1) ? $clog2(MAX_ALLOCS) : 1;
   localparam int ALLOC_CNT_W = $clog2(MAX_ALLOCS + 1);
   localparam int DIV_STEPS   = 32;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

   localparam logic [1:0] OP_ALLOC_FIT = 2'd0;
   localparam logic [1:0] OP_ALLOC_AT  = 2'd1;
   localparam logic [1:0] OP_RESIZE    = 2'd2;
   localparam logic [1:0] OP_FREE      = 2'd3;

   localparam logic [1:0] CSR_REGION_BASE = 2'd0;
   localparam logic [1:0] CSR_REGION_SIZE = 2'd1;
   localparam logic [1:0] CSR_ALIGNMENT   = 2'd2;

   localparam logic [31:0] RESET_REGION_SIZE = 32'd65536;

   typedef enum logic [3:0] {
      ST_OK            = 4'd0,
      ST_ZERO_SIZE     = 4'd1,
      ST_NO_SPACE      = 4'd2,
      ST_MISALIGNED    = 4'd3,
      ST_EXCEEDS       = 4'd4,
      ST_UNKNOWN_ID    = 4'd5,
      ST_LIFETIME_OPEN = 4'd6,
      ST_BUSY          = 4'd7,
      ST_TABLE_FULL    = 4'd8
   } status_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE, S_DIV_GO, S_DIV_WAIT, S_SIZE, S_OFF_CHK, S_SLOT_SCAN,
      S_ID_SCAN, S_RESIZE, S_FREE, S_SP_RD, S_SP_CHK, S_SP_FIT, S_GB_RD,
      S_GB_CHK, S_GB_DEC, S_ED_RD, S_ED_WR, S_ED_W0, S_ED_W1, S_FINISH, S_RESP
   } fsm_type;

   typedef enum logic [1:0] {ED_NONE, ED_UP, ED_DOWN} shift_type;
   typedef enum logic [1:0] {CNT_KEEP, CNT_INC, CNT_DEC} delta_type;
   typedef enum logic [1:0] {FIN_NEW, FIN_RESIZE, FIN_FREE} fin_type;

   typedef logic [33:0] wide_type;

   typedef struct packed {
      logic [31:0] off;
      logic [31:0] len;
   } span_type;

   typedef struct packed {
      logic [31:0] id;
      logic [31:0] off;
      logic [31:0] len;
      logic [2:0]  life;
   } alloc_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } urem_req_type;

   function automatic wide_type wx(input logic [31:0] v);
      return {2'b00, v};
   endfunction

endpackage

/* hdl/asa_ram.sv */
// generic simple dual port ram with registered read
module asa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* hdl/asa_urem.sv */
// bit serial unsigned remainder unit, one quotient bit per cycle
module asa_urem import asa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  urem_req_type req,
   output logic         busy,
   output logic [31:0]  rem
);
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]          q_ff, q_in;
   logic [31:0]          r_ff, r_in;
   logic [31:0]          d_ff, d_in;
   logic [32:0]          trial;
   logic                 take;

   assign trial = {r_ff, q_ff[31]};
   assign take  = trial >= {1'b0, d_ff};

   always_comb begin
      cnt_in = cnt_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      d_in   = d_ff;
      if (req.start) begin
         cnt_in = DIV_CNT_W'(DIV_STEPS);
         q_in   = req.dividend;
         r_in   = '0;
         d_in   = req.divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         q_in   = {q_ff[30:0], 1'b0};
         r_in   = take ? 32'(trial - {1'b0, d_ff}) : trial[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign busy = cnt_ff != '0;
   assign rem  = r_ff;
endmodule

/* hdl/aligned_span_allocator_core.sv */
// aligned span allocator: free span list and allocation table in rams, one request at a time
//
//   channel | direction | words
//   req_    | in        | op, size, offset, id, lifetime class, busy flag
//   rsp_    | out       | status, id, absolute address, aligned size
//   csr_    | in        | register index and data, a write to base, size or alignment restarts the allocator
//
// a request computes remainders (size, the offset of an alloc-at, and each span tried
// by first fit), scans allocation entries, reads each span tried by a search, passes
// spans in a give-back and moves spans when the list opens or closes a gap
// reset and each write to base, size or alignment rebuild the free list
// a finished word waits in the rsp register while the next request is taken
module aligned_span_allocator_core import asa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_op,
   input  logic [31:0] req_size,
   input  logic [31:0] req_offset,
   input  logic [31:0] req_id,
   input  logic [2:0]  req_lifetime_class,
   input  logic        req_range_busy,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [3:0]  rsp_status,
   output logic [31:0] rsp_result_id,
   output logic [31:0] rsp_result_address,
   output logic [31:0] rsp_result_size,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   fsm_type state_ff, state_in, div_ret_ff, div_ret_in;

   logic [31:0] base_ff, base_in, rsz_ff, rsz_in, algn_ff, algn_in;
   logic [1:0]  op_ff, op_in;
   logic [31:0] size_ff, size_in, off_ff, off_in, id_ff, id_in;
   logic [2:0]  life_ff, life_in;
   logic        busy_ff, busy_in;
   wide_type    aligned_ff, aligned_in;
   logic [31:0] div_arg_ff, div_arg_in;

   logic [SPAN_CNT_W-1:0]  cnt_ff, cnt_in, k_ff, k_in;
   logic [MAX_ALLOCS-1:0]  valid_ff, valid_in;
   logic [31:0]            next_id_ff, next_id_in;
   logic [ALLOC_CNT_W-1:0] scan_ff, scan_in;
   logic                   chk_ff, chk_in;
   logic [ALLOC_IDX_W-1:0] chk_idx_ff, chk_idx_in, hit_ff, hit_in;
   logic [31:0]            a_off_ff, a_off_in, a_len_ff, a_len_in;
   logic [2:0]             a_life_ff, a_life_in;
   span_type               sp_ff, sp_in, prev_ff, prev_in, cur_ff, cur_in;
   logic                   cur_ok_ff, cur_ok_in;
   logic [31:0]            start_ff, start_in, gs_ff, gs_in, glen_ff, glen_in;
   fin_type                fin_ff, fin_in;

   shift_type              ed_dir_ff, ed_dir_in;
   logic [SPAN_CNT_W-1:0]  ed_lo_ff, ed_lo_in, ed_ptr_ff, ed_ptr_in;
   delta_type              ed_cnt_ff, ed_cnt_in;
   logic                   w0_en_ff, w0_en_in, w1_en_ff, w1_en_in;
   logic [SPAN_IDX_W-1:0]  w0_addr_ff, w0_addr_in, w1_addr_ff, w1_addr_in;
   span_type               w0_data_ff, w0_data_in, w1_data_ff, w1_data_in;

   status_type  res_status_ff, res_status_in;
   logic [31:0] res_id_ff, res_id_in, res_off_ff, res_off_in, res_len_ff, res_len_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_id_ff, rsp_id_in, rsp_addr_ff, rsp_addr_in, rsp_len_ff, rsp_len_in;

   // rams and remainder unit
   logic                  sp_we;
   logic [SPAN_IDX_W-1:0] sp_waddr, sp_raddr;
   span_type              sp_wdata, sp_rdata;
   logic                  al_we;
   logic [ALLOC_IDX_W-1:0] al_waddr, al_raddr;
   alloc_type             al_wdata, al_rdata;
   urem_req_type          div_req;
   logic                  div_busy;
   logic [31:0]           rem;

   // decision terms
   logic [31:0] alg, up_add;
   wide_type    size_up, sp_end, fit_start, carve_len, carve_end, lead_len, after;
   logic        fit, carve_both, span_full, id_hit, scan_end, slot_free;
   logic        lt, rt, shift_more, off_exceed, rs_exceed, rsp_free;

   asa_ram #(.WIDTH($bits(span_type)), .DEPTH(MAX_SPANS)) u_span_ram (
      .clock(clock), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
      .raddr(sp_raddr), .rdata(sp_rdata)
   );

   asa_ram #(.WIDTH($bits(alloc_type)), .DEPTH(MAX_ALLOCS)) u_alloc_ram (
      .clock(clock), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
      .raddr(al_raddr), .rdata(al_rdata)
   );

   asa_urem u_urem (
      .clock(clock), .reset(reset), .req(div_req), .busy(div_busy), .rem(rem)
   );

   assign alg     = (algn_ff == '0) ? 32'd1 : algn_ff;
   assign up_add  = (rem == '0) ? '0 : alg - rem;
   assign size_up = wx(size_ff) + wx(up_add);

   assign span_full = cnt_ff >= SPAN_CNT_W'(MAX_SPANS);
   assign scan_end  = scan_ff == ALLOC_CNT_W'(MAX_ALLOCS);
   assign slot_free = !valid_ff[scan_ff[ALLOC_IDX_W-1:0]];
   assign id_hit    = chk_ff && valid_ff[chk_idx_ff] && (al_rdata.id == id_ff);
   assign off_exceed = wx(off_ff) + aligned_ff > wx(rsz_ff);
   assign rs_exceed  = wx(a_off_ff) + aligned_ff > wx(rsz_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   // fit test of the span held in sp_ff, by request kind
   assign sp_end = wx(sp_ff.off) + wx(sp_ff.len);
   always_comb begin
      case (op_ff)
         OP_ALLOC_FIT: begin
            fit_start = wx(sp_ff.off) + wx(up_add);
            carve_len = aligned_ff;
            fit = (wx(up_add) <= wx(sp_ff.len)) &&
                  (aligned_ff <= wx(sp_ff.len) - wx(up_add));
         end
         OP_ALLOC_AT: begin
            fit_start = wx(off_ff);
            carve_len = aligned_ff;
            fit = (off_ff >= sp_ff.off) && (wx(off_ff) + aligned_ff <= sp_end);
         end
         default: begin
            // grow into the span right after the allocation
            fit_start = wx(a_off_ff) + wx(a_len_ff);
            carve_len = aligned_ff - wx(a_len_ff);
            fit = (fit_start >= wx(sp_ff.off)) && (wx(a_off_ff) + aligned_ff <= sp_end);
         end
      endcase
   end
   assign carve_end  = fit_start + carve_len;
   assign lead_len   = fit_start - wx(sp_ff.off);
   assign after      = sp_end - carve_end;
   assign carve_both = (lead_len != '0) && (after != '0);

   assign lt = (k_ff != '0) && (wx(prev_ff.off) + wx(prev_ff.len) == wx(gs_ff));
   assign rt = cur_ok_ff && (wx(cur_ff.off) == wx(gs_ff) + wx(glen_ff));

   always_comb begin
      case (ed_dir_ff)
         ED_UP:   shift_more = ed_ptr_ff > ed_lo_ff;
         ED_DOWN: shift_more = ({1'b0, ed_ptr_ff} + 1'b1) < {1'b0, cnt_ff};
         default: shift_more = 1'b0;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: state_in = S_IDLE;
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_index == CSR_REGION_BASE || csr_index == CSR_REGION_SIZE ||
                   csr_index == CSR_ALIGNMENT) begin
                  state_in = S_INIT;
               end
            end else if (req_valid) begin
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: state_in = S_DIV_WAIT;
         S_DIV_WAIT: begin
            if (!div_busy) begin
               state_in = div_ret_ff;
            end
         end
         S_SIZE: begin
            if (op_ff == OP_RESIZE || op_ff == OP_FREE) begin
               state_in = S_ID_SCAN;
            end else if (size_ff == '0) begin
               state_in = S_RESP;
            end else if (op_ff == OP_ALLOC_AT) begin
               state_in = S_DIV_GO;
            end else begin
               state_in = S_SLOT_SCAN;
            end
         end
         S_OFF_CHK: state_in = (rem != '0 || off_exceed) ? S_RESP : S_SLOT_SCAN;
         S_SLOT_SCAN: begin
            if (scan_end) begin
               state_in = S_RESP;
            end else if (slot_free) begin
               state_in = S_SP_RD;
            end
         end
         S_ID_SCAN: begin
            if (id_hit) begin
               state_in = (op_ff == OP_RESIZE) ? S_RESIZE : S_FREE;
            end else if (scan_end) begin
               state_in = S_RESP;
            end
         end
         S_RESIZE: begin
            if (size_ff == '0 || aligned_ff == wx(a_len_ff) || rs_exceed) begin
               state_in = S_RESP;
            end else if (aligned_ff < wx(a_len_ff)) begin
               state_in = S_GB_RD;
            end else begin
               state_in = S_SP_RD;
            end
         end
         S_FREE: state_in = (a_life_ff > life_ff || busy_ff) ? S_RESP : S_GB_RD;
         S_SP_RD: state_in = (k_ff >= cnt_ff) ? S_RESP : S_SP_CHK;
         S_SP_CHK: state_in = (op_ff == OP_ALLOC_FIT) ? S_DIV_GO : S_SP_FIT;
         S_SP_FIT: begin
            if (!fit) begin
               state_in = S_SP_RD;
            end else if (carve_both && span_full) begin
               state_in = S_RESP;
            end else begin
               state_in = S_ED_RD;
            end
         end
         S_GB_RD: state_in = (k_ff >= cnt_ff) ? S_GB_DEC : S_GB_CHK;
         S_GB_CHK: state_in = (sp_rdata.off < gs_ff) ? S_GB_RD : S_GB_DEC;
         S_GB_DEC: state_in = (!lt && !rt && span_full) ? S_RESP : S_ED_RD;
         S_ED_RD: state_in = shift_more ? S_ED_WR : S_ED_W0;
         S_ED_WR: state_in = S_ED_RD;
         S_ED_W0: state_in = S_ED_W1;
         S_ED_W1: state_in = S_FINISH;
         S_FINISH: state_in = S_RESP;
         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      base_in = base_ff;  rsz_in = rsz_ff;  algn_in = algn_ff;
      op_in = op_ff;  size_in = size_ff;  off_in = off_ff;  id_in = id_ff;
      life_in = life_ff;  busy_in = busy_ff;  aligned_in = aligned_ff;
      div_arg_in = div_arg_ff;  div_ret_in = div_ret_ff;
      cnt_in = cnt_ff;  k_in = k_ff;  valid_in = valid_ff;  next_id_in = next_id_ff;
      scan_in = scan_ff;  chk_in = chk_ff;  chk_idx_in = chk_idx_ff;  hit_in = hit_ff;
      a_off_in = a_off_ff;  a_len_in = a_len_ff;  a_life_in = a_life_ff;
      sp_in = sp_ff;  prev_in = prev_ff;  cur_in = cur_ff;  cur_ok_in = cur_ok_ff;
      start_in = start_ff;  gs_in = gs_ff;  glen_in = glen_ff;  fin_in = fin_ff;
      ed_dir_in = ed_dir_ff;  ed_lo_in = ed_lo_ff;  ed_ptr_in = ed_ptr_ff;
      ed_cnt_in = ed_cnt_ff;
      w0_en_in = w0_en_ff;  w0_addr_in = w0_addr_ff;  w0_data_in = w0_data_ff;
      w1_en_in = w1_en_ff;  w1_addr_in = w1_addr_ff;  w1_data_in = w1_data_ff;
      res_status_in = res_status_ff;  res_id_in = res_id_ff;
      res_off_in = res_off_ff;  res_len_in = res_len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;  rsp_id_in = rsp_id_ff;
      rsp_addr_in = rsp_addr_ff;  rsp_len_in = rsp_len_ff;

      sp_we = 1'b0;  sp_waddr = k_ff[SPAN_IDX_W-1:0];  sp_wdata = w0_data_ff;
      sp_raddr = k_ff[SPAN_IDX_W-1:0];
      al_we = 1'b0;  al_waddr = hit_ff;  al_wdata = '0;
      al_raddr = scan_ff[ALLOC_IDX_W-1:0];
      div_req.start = 1'b0;  div_req.dividend = div_arg_ff;  div_req.divisor = alg;

      case (state_ff)
         S_INIT: begin
            sp_we = 1'b1;
            sp_waddr = '0;
            sp_wdata = '{off: 32'd0, len: rsz_ff};
            cnt_in = (rsz_ff != '0) ? SPAN_CNT_W'(1) : '0;
            valid_in = '0;
            next_id_in = '0;
         end
         S_IDLE: begin
            if (csr_valid) begin
               case (csr_index)
                  CSR_REGION_BASE: base_in = csr_data;
                  CSR_REGION_SIZE: rsz_in = csr_data;
                  CSR_ALIGNMENT:   algn_in = csr_data;
                  default: ;
               endcase
            end else if (req_valid) begin
               op_in = req_op;
               size_in = req_size;
               off_in = req_offset;
               id_in = req_id;
               life_in = req_lifetime_class;
               busy_in = req_range_busy;
               div_arg_in = req_size;
               div_ret_in = S_SIZE;
            end
         end
         S_DIV_GO: div_req.start = 1'b1;
         S_SIZE: begin
            aligned_in = size_up;
            scan_in = '0;
            chk_in = 1'b0;
            if (op_ff == OP_ALLOC_FIT || op_ff == OP_ALLOC_AT) begin
               if (size_ff == '0) begin
                  res_status_in = ST_ZERO_SIZE;
               end
               div_arg_in = off_ff;
               div_ret_in = S_OFF_CHK;
            end
         end
         S_OFF_CHK: begin
            if (rem != '0) begin
               res_status_in = ST_MISALIGNED;
            end else if (off_exceed) begin
               res_status_in = ST_EXCEEDS;
            end
         end
         S_SLOT_SCAN: begin
            if (scan_end) begin
               res_status_in = ST_TABLE_FULL;
            end else if (slot_free) begin
               hit_in = scan_ff[ALLOC_IDX_W-1:0];
               fin_in = FIN_NEW;
               k_in = '0;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_ID_SCAN: begin
            // read of entry scan lands in the following cycle for the compare
            if (id_hit) begin
               hit_in = chk_idx_ff;
               a_off_in = al_rdata.off;
               a_len_in = al_rdata.len;
               a_life_in = al_rdata.life;
            end else if (scan_end) begin
               res_status_in = ST_UNKNOWN_ID;
            end else begin
               chk_in = 1'b1;
               chk_idx_in = scan_ff[ALLOC_IDX_W-1:0];
               scan_in = scan_ff + 1'b1;
            end
         end
         S_RESIZE: begin
            k_in = '0;
            fin_in = FIN_RESIZE;
            if (size_ff == '0) begin
               res_status_in = ST_ZERO_SIZE;
            end else if (aligned_ff == wx(a_len_ff)) begin
               res_status_in = ST_OK;
               res_id_in = id_ff;
               res_off_in = a_off_ff;
               res_len_in = a_len_ff;
            end else if (rs_exceed) begin
               res_status_in = ST_EXCEEDS;
            end else begin
               gs_in = a_off_ff + aligned_ff[31:0];
               glen_in = a_len_ff - aligned_ff[31:0];
            end
         end
         S_FREE: begin
            k_in = '0;
            fin_in = FIN_FREE;
            gs_in = a_off_ff;
            glen_in = a_len_ff;
            if (a_life_ff > life_ff) begin
               res_status_in = ST_LIFETIME_OPEN;
            end else if (busy_ff) begin
               res_status_in = ST_BUSY;
            end
         end
         S_SP_RD: begin
            if (k_ff >= cnt_ff) begin
               res_status_in = ST_NO_SPACE;
            end
         end
         S_SP_CHK: begin
            sp_in = sp_rdata;
            div_arg_in = sp_rdata.off;
            div_ret_in = S_SP_FIT;
         end
         S_SP_FIT: begin
            start_in = fit_start[31:0];
            w0_addr_in = k_ff[SPAN_IDX_W-1:0];
            w1_addr_in = SPAN_IDX_W'(k_ff + 1'b1);
            w1_data_in = '{off: carve_end[31:0], len: after[31:0]};
            ed_lo_in = k_ff + 1'b1;
            ed_ptr_in = cnt_ff;
            if (!fit) begin
               k_in = k_ff + 1'b1;
            end else if (carve_both) begin
               if (span_full) begin
                  res_status_in = ST_TABLE_FULL;
               end
               ed_dir_in = ED_UP;
               ed_cnt_in = CNT_INC;
               w0_en_in = 1'b1;
               w1_en_in = 1'b1;
               w0_data_in = '{off: sp_ff.off, len: lead_len[31:0]};
            end else if (lead_len != '0) begin
               ed_dir_in = ED_NONE;
               ed_cnt_in = CNT_KEEP;
               w0_en_in = 1'b1;
               w1_en_in = 1'b0;
               w0_data_in = '{off: sp_ff.off, len: lead_len[31:0]};
            end else if (after != '0) begin
               ed_dir_in = ED_NONE;
               ed_cnt_in = CNT_KEEP;
               w0_en_in = 1'b1;
               w1_en_in = 1'b0;
               w0_data_in = '{off: carve_end[31:0], len: after[31:0]};
            end else begin
               // span used up exactly, close the gap
               ed_dir_in = ED_DOWN;
               ed_cnt_in = CNT_DEC;
               ed_lo_in = k_ff;
               ed_ptr_in = k_ff;
               w0_en_in = 1'b0;
               w1_en_in = 1'b0;
            end
         end
         S_GB_RD: begin
            if (k_ff >= cnt_ff) begin
               cur_ok_in = 1'b0;
            end
         end
         S_GB_CHK: begin
            if (sp_rdata.off < gs_ff) begin
               prev_in = sp_rdata;
               k_in = k_ff + 1'b1;
            end else begin
               cur_in = sp_rdata;
               cur_ok_in = 1'b1;
            end
         end
         S_GB_DEC: begin
            w1_en_in = 1'b0;
            ed_lo_in = k_ff;
            if (lt && rt) begin
               ed_dir_in = ED_DOWN;
               ed_cnt_in = CNT_DEC;
               ed_ptr_in = k_ff;
               w0_en_in = 1'b1;
               w0_addr_in = SPAN_IDX_W'(k_ff - 1'b1);
               w0_data_in = '{off: prev_ff.off, len: prev_ff.len + glen_ff + cur_ff.len};
            end else if (lt) begin
               ed_dir_in = ED_NONE;
               ed_cnt_in = CNT_KEEP;
               w0_en_in = 1'b1;
               w0_addr_in = SPAN_IDX_W'(k_ff - 1'b1);
               w0_data_in = '{off: prev_ff.off, len: prev_ff.len + glen_ff};
            end else if (rt) begin
               ed_dir_in = ED_NONE;
               ed_cnt_in = CNT_KEEP;
               w0_en_in = 1'b1;
               w0_addr_in = k_ff[SPAN_IDX_W-1:0];
               w0_data_in = '{off: gs_ff, len: cur_ff.len + glen_ff};
            end else begin
               if (span_full) begin
                  res_status_in = ST_TABLE_FULL;
               end
               ed_dir_in = ED_UP;
               ed_cnt_in = CNT_INC;
               ed_ptr_in = cnt_ff;
               w0_en_in = 1'b1;
               w0_addr_in = k_ff[SPAN_IDX_W-1:0];
               w0_data_in = '{off: gs_ff, len: glen_ff};
            end
         end
         S_ED_RD: begin
            sp_raddr = (ed_dir_ff == ED_UP) ? SPAN_IDX_W'(ed_ptr_ff - 1'b1)
                                            : SPAN_IDX_W'(ed_ptr_ff + 1'b1);
         end
         S_ED_WR: begin
            sp_we = 1'b1;
            sp_waddr = ed_ptr_ff[SPAN_IDX_W-1:0];
            sp_wdata = sp_rdata;
            ed_ptr_in = (ed_dir_ff == ED_UP) ? ed_ptr_ff - 1'b1 : ed_ptr_ff + 1'b1;
         end
         S_ED_W0: begin
            sp_we = w0_en_ff;
            sp_waddr = w0_addr_ff;
            sp_wdata = w0_data_ff;
         end
         S_ED_W1: begin
            sp_we = w1_en_ff;
            sp_waddr = w1_addr_ff;
            sp_wdata = w1_data_ff;
            case (ed_cnt_ff)
               CNT_INC: cnt_in = cnt_ff + 1'b1;
               CNT_DEC: cnt_in = cnt_ff - 1'b1;
               default: cnt_in = cnt_ff;
            endcase
         end
         S_FINISH: begin
            res_status_in = ST_OK;
            res_id_in = id_ff;
            res_off_in = a_off_ff;
            res_len_in = aligned_ff[31:0];
            case (fin_ff)
               FIN_NEW: begin
                  al_we = 1'b1;
                  al_wdata = '{id: next_id_ff, off: start_ff, len: aligned_ff[31:0],
                               life: life_ff};
                  valid_in[hit_ff] = 1'b1;
                  next_id_in = next_id_ff + 1'b1;
                  res_id_in = next_id_ff;
                  res_off_in = start_ff;
               end
               FIN_RESIZE: begin
                  al_we = 1'b1;
                  al_wdata = '{id: id_ff, off: a_off_ff, len: aligned_ff[31:0],
                               life: a_life_ff};
               end
               default: begin
                  valid_in[hit_ff] = 1'b0;
                  res_len_in = a_len_ff;
               end
            endcase
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = res_status_ff;
               if (res_status_ff == ST_OK) begin
                  rsp_id_in = res_id_ff;
                  rsp_addr_in = base_ff + res_off_ff;
                  rsp_len_in = res_len_ff;
               end else begin
                  rsp_id_in = '0;
                  rsp_addr_in = '0;
                  rsp_len_in = '0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         base_ff <= '0;
         rsz_ff <= RESET_REGION_SIZE;
         algn_ff <= 32'd1;
         cnt_ff <= '0;
         valid_ff <= '0;
         next_id_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         base_ff <= base_in;
         rsz_ff <= rsz_in;
         algn_ff <= algn_in;
         cnt_ff <= cnt_in;
         valid_ff <= valid_in;
         next_id_ff <= next_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      div_ret_ff <= div_ret_in;
      op_ff <= op_in;  size_ff <= size_in;  off_ff <= off_in;  id_ff <= id_in;
      life_ff <= life_in;  busy_ff <= busy_in;  aligned_ff <= aligned_in;
      div_arg_ff <= div_arg_in;  k_ff <= k_in;  scan_ff <= scan_in;
      chk_ff <= chk_in;  chk_idx_ff <= chk_idx_in;  hit_ff <= hit_in;
      a_off_ff <= a_off_in;  a_len_ff <= a_len_in;  a_life_ff <= a_life_in;
      sp_ff <= sp_in;  prev_ff <= prev_in;  cur_ff <= cur_in;  cur_ok_ff <= cur_ok_in;
      start_ff <= start_in;  gs_ff <= gs_in;  glen_ff <= glen_in;  fin_ff <= fin_in;
      ed_dir_ff <= ed_dir_in;  ed_lo_ff <= ed_lo_in;  ed_ptr_ff <= ed_ptr_in;
      ed_cnt_ff <= ed_cnt_in;
      w0_en_ff <= w0_en_in;  w0_addr_ff <= w0_addr_in;  w0_data_ff <= w0_data_in;
      w1_en_ff <= w1_en_in;  w1_addr_ff <= w1_addr_in;  w1_data_ff <= w1_data_in;
      res_status_ff <= res_status_in;  res_id_ff <= res_id_in;
      res_off_ff <= res_off_in;  res_len_ff <= res_len_in;
      rsp_status_ff <= rsp_status_in;  rsp_id_ff <= rsp_id_in;
      rsp_addr_ff <= rsp_addr_in;  rsp_len_ff <= rsp_len_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_result_id = rsp_id_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_result_size = rsp_len_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) div_busy |-> !div_req.start)
      else $error("remainder unit restarted while busy");
   assert property (@(posedge clock) disable iff (reset) cnt_ff <= SPAN_CNT_W'(MAX_SPANS))
      else $error("free span count beyond table depth");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ED_W1 && ed_cnt_ff == CNT_INC) |-> cnt_ff < SPAN_CNT_W'(MAX_SPANS))
      else $error("span inserted into a full list");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && fin_ff == FIN_NEW) |-> !valid_ff[hit_ff])
      else $error("new allocation placed on a live entry");
`endif
endmodule
